/* hdl/idr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package idr_pkg;

  localparam int W = 64;
  localparam int PORT_W = 64;

  localparam logic [1:0] OP_UQUO = 2'd0;
  localparam logic [1:0] OP_UREM = 2'd1;
  localparam logic [1:0] OP_SQUO = 2'd2;
  localparam logic [1:0] OP_SREM = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef logic [W-1:0] word_t;
  typedef logic [2*W-1:0] rq_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       neg_q;
    logic       neg_r;
    logic [1:0] st;
  } ctl_t;

endpackage
`default_nettype wire

/* hdl/idr_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
module idr_prep (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [1:0]                 opcode,
  input  wire logic [idr_pkg::PORT_W-1:0] dividend,
  input  wire logic [idr_pkg::PORT_W-1:0] divisor,
  output idr_pkg::ctl_t                   ctl,
  output idr_pkg::rq_t                    rq,
  output idr_pkg::word_t                  dsr
);

  idr_pkg::word_t a;
  idr_pkg::word_t b;
  idr_pkg::word_t a_abs;
  idr_pkg::word_t b_abs;
  idr_pkg::word_t w_sign;
  logic           is_signed;
  logic           an;
  logic           bn;
  idr_pkg::ctl_t  ctl_next;

  always_comb begin
    a         = dividend[idr_pkg::W-1:0];
    b         = divisor[idr_pkg::W-1:0];
    w_sign    = {1'b1, {(idr_pkg::W-1){1'b0}}};
    is_signed = opcode[1];
    an        = is_signed & a[idr_pkg::W-1];
    bn        = is_signed & b[idr_pkg::W-1];
    a_abs     = an ? -a : a;
    b_abs     = bn ? -b : b;

    ctl_next.valid = start;
    ctl_next.op    = opcode;
    ctl_next.neg_q = (opcode == idr_pkg::OP_SQUO) && (an != bn);
    ctl_next.neg_r = (opcode == idr_pkg::OP_SREM) && an;
    if (b == '0) begin
      ctl_next.st = idr_pkg::ST_DIVZERO;
    end else if (opcode == idr_pkg::OP_SQUO && a == w_sign && b == '1) begin
      ctl_next.st = idr_pkg::ST_OVERFLOW;
    end else begin
      ctl_next.st = idr_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    rq  <= {{idr_pkg::W{1'b0}}, a_abs};
    dsr <= b_abs;
  end

endmodule
`default_nettype wire

/* hdl/idr_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module idr_step (
  input  wire logic           clk,
  input  wire logic           rst,
  input  idr_pkg::ctl_t       ctl_in,
  input  idr_pkg::rq_t        rq_in,
  input  idr_pkg::word_t      dsr_in,
  output idr_pkg::ctl_t       ctl_out,
  output idr_pkg::rq_t        rq_out,
  output idr_pkg::word_t      dsr_out
);

  logic [idr_pkg::W:0] rem_sh;
  logic [idr_pkg::W:0] diff;
  logic                take;
  idr_pkg::word_t      rem_new;
  idr_pkg::rq_t        rq_next;

  // partial remainder shifted left with next dividend bit; bit W is the carry
  always_comb begin
    rem_sh  = rq_in[2*idr_pkg::W-1:idr_pkg::W-1];
    diff    = rem_sh - {1'b0, dsr_in};
    take    = ~diff[idr_pkg::W];
    rem_new = take ? diff[idr_pkg::W-1:0] : rem_sh[idr_pkg::W-1:0];
    rq_next = {rem_new, rq_in[idr_pkg::W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rq_out  <= rq_next;
    dsr_out <= dsr_in;
  end

endmodule
`default_nettype wire

/* hdl/idr_post.sv */
`timescale 1ns / 1ps
`default_nettype none
module idr_post (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  idr_pkg::ctl_t                    ctl,
  input  idr_pkg::rq_t                     rq,
  output logic                             done,
  output logic [idr_pkg::PORT_W-1:0]       answer,
  output logic [1:0]                       status
);

  idr_pkg::word_t quo;
  idr_pkg::word_t rem;
  idr_pkg::word_t pick;
  logic           neg;
  idr_pkg::word_t ans;

  always_comb begin
    quo  = rq[idr_pkg::W-1:0];
    rem  = rq[2*idr_pkg::W-1:idr_pkg::W];
    pick = ctl.op[0] ? rem : quo;
    neg  = ctl.op[0] ? ctl.neg_r : ctl.neg_q;
    ans  = neg ? -pick : pick;
    if (ctl.st != idr_pkg::ST_OK) begin
      ans = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    answer <= idr_pkg::PORT_W'(ans);
    status <= ctl.st;
  end

endmodule
`default_nettype wire

/* hdl/int64_divide_remainder.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipelined 64-bit divider giving unsigned or signed quotient or remainder.
// A word is taken on every cycle that start is high; busy is never raised,
// since nothing inside can stall. Each result is shown on answer and status
// for one cycle with done high, after its word has passed through the
// pipeline: one operand stage that takes magnitudes and flags zero
// divisor and signed overflow, one restoring subtract stage per quotient
// bit, and one stage that fixes the sign and selects the result. Results
// leave in the order the words came in. The receiver must take each result
// in the cycle it is shown. On an error status, answer is zero.
module int64_divide_remainder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      answer,
  output logic [1:0]       status
);

  localparam int LATENCY = idr_pkg::W + 2;

  idr_pkg::ctl_t  ctl_s [0:idr_pkg::W];
  idr_pkg::rq_t   rq_s  [0:idr_pkg::W];
  idr_pkg::word_t dsr_s [0:idr_pkg::W];

  assign busy = 1'b0;

  idr_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .opcode   (opcode),
    .dividend (dividend),
    .divisor  (divisor),
    .ctl      (ctl_s[0]),
    .rq       (rq_s[0]),
    .dsr      (dsr_s[0])
  );

  for (genvar i = 0; i < idr_pkg::W; i++) begin : g_step
    idr_step u_step (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_s[i]),
      .rq_in   (rq_s[i]),
      .dsr_in  (dsr_s[i]),
      .ctl_out (ctl_s[i+1]),
      .rq_out  (rq_s[i+1]),
      .dsr_out (dsr_s[i+1])
    );
  end

  idr_post u_post (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl_s[idr_pkg::W]),
    .rq     (rq_s[idr_pkg::W]),
    .done   (done),
    .answer (answer),
    .status (status)
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3)
    else $error("bad status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != idr_pkg::ST_OK) |-> answer == '0)
    else $error("nonzero answer on error");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after pipeline latency");

  a_divzero: assert property (@(posedge clk) disable iff (rst)
    (start && divisor[idr_pkg::W-1:0] == '0) |-> ##LATENCY
      (done && status == idr_pkg::ST_DIVZERO))
    else $error("zero divisor not flagged");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import idr_pkg::*;

  localparam word_t MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam word_t MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam word_t ALL_ONES = '1;
  localparam int RANDOM_PER_PHASE = 600;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    word_t answer;
    logic [1:0] status;
  } div_result_t;

  typedef struct {
    logic [1:0] op;
    word_t a;
    word_t b;
    bit typed;
    word_t ans;
    logic [1:0] st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = OP_UQUO;
  logic [63:0] dividend = '0;
  logic [63:0] divisor = '0;
  logic busy;
  logic done;
  logic [63:0] answer;
  logic [1:0] status;

  // typed expectation that travels with the word being offered
  bit row_typed = 1'b0;
  word_t row_ans = '0;
  logic [1:0] row_st = ST_OK;

  div_result_t pending_results[$];
  div_result_t oldest;
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  int64_divide_remainder u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .dividend(dividend),
    .divisor(divisor),
    .done(done),
    .answer(answer),
    .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic div_result_t divide_predict(logic [1:0] op, word_t a, word_t b);
    div_result_t res;
    word_t mag_a, mag_b, q, r;
    logic carry;
    bit is_signed, a_neg, b_neg;
    res.answer = '0;
    res.status = ST_OK;
    is_signed = (op == OP_SQUO) || (op == OP_SREM);
    a_neg = is_signed && a[W-1];
    b_neg = is_signed && b[W-1];
    if (b == '0) begin
      res.status = ST_DIVZERO;
    end else if (op == OP_SQUO && a == MOST_NEG && b == ALL_ONES) begin
      res.status = ST_OVERFLOW;
    end else begin
      mag_a = a_neg ? -a : a;
      mag_b = b_neg ? -b : b;
      q = '0;
      r = '0;
      for (int i = W - 1; i >= 0; i--) begin
        carry = r[W-1];
        r = {r[W-2:0], mag_a[i]};
        if (carry || r >= mag_b) begin
          r = r - mag_b;
          q[i] = 1'b1;
        end
      end
      case (op)
        OP_UQUO: res.answer = q;
        OP_UREM: res.answer = r;
        OP_SQUO: res.answer = (a_neg != b_neg) ? -q : q;
        default: res.answer = a_neg ? -r : r;
      endcase
    end
    return res;
  endfunction

  function automatic word_t pick_operand();
    word_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      3: v = word_t'($urandom_range(0, 15));
      4: v = -word_t'($urandom_range(1, 15));
      5: v = word_t'(1) << $urandom_range(0, W - 1);
      6: v = (word_t'(1) << $urandom_range(0, W - 1)) - 1;
      7: v = v >> $urandom_range(1, W - 1);
      8: begin
        case ($urandom_range(0, 3))
          0: v = MOST_NEG;
          1: v = ALL_ONES;
          2: v = MAX_POS;
          default: v = MOST_NEG + 1;
        endcase
      end
      9: v = -(v >> $urandom_range(1, W - 1));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_word(input stim_row_t row);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= row.op;
    dividend <= row.a;
    divisor <= row.b;
    row_typed <= row.typed;
    row_ans <= row.ans;
    row_st <= row.st;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // check results against the oldest expectation, queue an expectation per accepted word
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result answer %h status %0d", $time, answer, status);
          errors++;
        end else begin
          oldest = pending_results.pop_front();
          if (answer !== oldest.answer) begin
            $display("%0t: answer mismatch expected %h actual %h", $time, oldest.answer,
                     answer);
            errors++;
          end
          if (status !== oldest.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, oldest.status,
                     status);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (row_typed) pending_results.push_back('{row_ans, row_st});
        else pending_results.push_back(divide_predict(opcode, dividend, divisor));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t directed_rows [22];
    stim_row_t row;
    directed_rows = '{
      '{OP_UQUO, 64'd0, 64'd0, 1'b1, 64'd0, ST_DIVZERO},
      '{OP_UREM, ALL_ONES, 64'd0, 1'b1, 64'd0, ST_DIVZERO},
      '{OP_SQUO, 64'd5, 64'd0, 1'b1, 64'd0, ST_DIVZERO},
      '{OP_SREM, MOST_NEG, 64'd0, 1'b1, 64'd0, ST_DIVZERO},
      '{OP_SQUO, MOST_NEG, ALL_ONES, 1'b1, 64'd0, ST_OVERFLOW},
      '{OP_SREM, MOST_NEG, ALL_ONES, 1'b1, 64'd0, ST_OK},
      '{OP_UQUO, ALL_ONES, 64'd1, 1'b1, ALL_ONES, ST_OK},
      '{OP_UREM, ALL_ONES, 64'd1, 1'b1, 64'd0, ST_OK},
      '{OP_UQUO, ALL_ONES, ALL_ONES, 1'b1, 64'd1, ST_OK},
      '{OP_UQUO, 64'd0, ALL_ONES, 1'b1, 64'd0, ST_OK},
      '{OP_SQUO, MOST_NEG, 64'd1, 1'b1, MOST_NEG, ST_OK},
      '{OP_SQUO, ALL_ONES, ALL_ONES, 1'b1, 64'd1, ST_OK},
      '{OP_UQUO, ALL_ONES, MOST_NEG, 1'b0, 64'd0, ST_OK},
      '{OP_UREM, ALL_ONES, MOST_NEG, 1'b0, 64'd0, ST_OK},
      '{OP_SQUO, 64'hffff_ffff_ffff_fff9, 64'd2, 1'b0, 64'd0, ST_OK},
      '{OP_SREM, 64'hffff_ffff_ffff_fff9, 64'd2, 1'b0, 64'd0, ST_OK},
      '{OP_SREM, 64'd7, 64'hffff_ffff_ffff_fffe, 1'b0, 64'd0, ST_OK},
      '{OP_SQUO, MOST_NEG, MOST_NEG, 1'b0, 64'd0, ST_OK},
      '{OP_SREM, MAX_POS, MOST_NEG, 1'b0, 64'd0, ST_OK},
      '{OP_UQUO, 64'hdead_beef_cafe_f00d, 64'd3, 1'b0, 64'd0, ST_OK},
      '{OP_SQUO, MAX_POS, ALL_ONES, 1'b0, 64'd0, ST_OK},
      '{OP_UREM, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'd0, ST_OK}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_word(directed_rows[i]);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 56 : 0;
      repeat (RANDOM_PER_PHASE) begin
        row.op = 2'($urandom_range(0, 3));
        row.a = pick_operand();
        row.b = pick_operand();
        row.typed = 1'b0;
        row.ans = '0;
        row.st = ST_OK;
        if ($urandom_range(0, 99) < 3) row.b = '0;
        else if ($urandom_range(0, 99) < 3) begin
          row.a = MOST_NEG;
          row.b = ALL_ONES;
        end
        send_word(row);
      end
      // pause until the pipe has drained
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (W + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
